// File: sv/hmu_pkg.sv
// ----------------------------------------------------------------------------
// hmu_pkg: shared definitions for the histogram matching unit
// Default sizes used by the top level and the divider, and command codes for the top level.
// ----------------------------------------------------------------------------
package hmu_pkg;

  localparam int LEVELS_DEFAULT      = 256;
  localparam int COUNT_WIDTH_DEFAULT = 24;

  localparam logic [2:0] OP_ADD_REF = 3'd0;
  localparam logic [2:0] OP_ADD_IN  = 3'd1;
  localparam logic [2:0] OP_BUILD   = 3'd2;
  localparam logic [2:0] OP_MAP     = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

endpackage

// File: sv/hmu_divider.sv
// ----------------------------------------------------------------------------
// hmu_divider: iterative transfer scaler
// Computes floor((LEVELS-1)*cum/total) by restoring division, one quotient
// bit per cycle. A zero total gives a zero quotient.
// ----------------------------------------------------------------------------
module hmu_divider
  import hmu_pkg::*;
#(
  parameter int LEVELS      = LEVELS_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [COUNT_WIDTH-1:0]    cum,
  input  logic [COUNT_WIDTH-1:0]    total,
  output logic                      done,
  output logic [$clog2(LEVELS)-1:0] quotient
);

  localparam int LW = $clog2(LEVELS);
  localparam int CW = COUNT_WIDTH;
  localparam int NW = $clog2(LW + 1);

  logic          run;
  logic [NW-1:0] cnt;
  logic [CW-1:0] rem;
  logic [LW-1:0] low;
  logic [CW-1:0] den;
  logic [LW-1:0] q;

  logic [CW+LW-1:0] num;
  logic [CW:0]      trial;
  logic             ge;
  logic [CW:0]      diff;
  logic [LW:0]      q_shift;
  logic [LW:0]      low_shift;

  // The dividend (LEVELS-1)*cum is a multiply by a small constant. Since
  // cum never exceeds total, the upper CW bits start below the divisor and
  // the quotient fits in LW bits.
  assign num       = (CW + LW)'(cum) * (CW + LW)'(LEVELS - 1);
  assign trial     = {rem, low[LW-1]};
  assign ge        = (trial >= {1'b0, den});
  assign diff      = trial - {1'b0, den};
  assign q_shift   = {q, ge};
  assign low_shift = {low, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den <= total;
        rem <= num[CW+LW-1:LW];
        low <= num[LW-1:0];
        q   <= '0;
        cnt <= NW'(LW);
        if (total == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          run <= 1'b1;
        end
      end else if (run) begin
        rem <= ge ? diff[CW-1:0] : trial[CW-1:0];
        low <= low_shift[LW-1:0];
        q   <= q_shift[LW-1:0];
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;

`ifndef SYNTHESIS
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run) || $past(start)) else $error("divider done without work");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done && !start |=> !done) else $error("divider done held");
  a_run_no_done: assert property (@(posedge clk) disable iff (rst)
    run |-> !done) else $error("divider done while running");
`endif

endmodule

// File: sv/histogram_matching_unit.sv
// ----------------------------------------------------------------------------
// histogram_matching_unit: grayscale histogram matching engine
// Counts reference and input pixels, builds a matching map, maps pixels.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                      | Handshake
//  ---------+----------------------------+--------------------------------
//  command  | start, op, pixel_value     | taken when start && !busy
//  result   | valid, matched_value       | one-cycle strobe, no backpressure
//
// An add request reads the histogram, then writes the count back, and a map
// request reads the map, then strobes the result.
// A build request walks both histograms through the shared divider, which
// produces one quotient bit per cycle.
// Reset and a clear request each start a clearing pass through the histogram
// memories and the final map, during which busy stays high.
// The receiver cannot stall: a result is valid for exactly one cycle.
module histogram_matching_unit
  import hmu_pkg::*;
#(
  parameter int LEVELS      = LEVELS_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op,
  input  logic [7:0] pixel_value,
  output logic       valid,
  output logic [7:0] matched_value
);

  localparam int LW = $clog2(LEVELS);
  localparam int CW = COUNT_WIDTH;
  localparam logic [LW-1:0] LAST = LW'(LEVELS - 1);

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_ADD   = 4'd2;
  localparam logic [3:0] ST_MAP   = 4'd3;
  localparam logic [3:0] ST_ISSUE = 4'd4;
  localparam logic [3:0] ST_RD    = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_FILL  = 4'd7;
  localparam logic [3:0] ST_TAIL  = 4'd8;
  localparam logic [3:0] ST_INV   = 4'd9;

  // Memories.
  logic [CW-1:0] ref_hist  [LEVELS];
  logic [CW-1:0] in_hist   [LEVELS];
  logic [LW-1:0] inv_map   [LEVELS];
  logic [LW-1:0] final_map [LEVELS];

  logic [CW-1:0] ref_q;
  logic [CW-1:0] in_q;
  logic [LW-1:0] inv_q;
  logic [LW-1:0] final_q;

  // Control registers.
  logic [3:0]    state;
  logic [LW-1:0] i;
  logic [LW-1:0] w;
  logic [LW-1:0] p;
  logic [LW-1:0] v;
  logic [LW-1:0] lp;
  logic [LW-1:0] lv;
  logic [LW-1:0] np;
  logic [LW-1:0] nv;
  logic          haslp;
  logic          first;
  logic          ending;
  logic          pass;
  logic          add_sel;
  logic [LW-1:0] add_addr;
  logic [CW-1:0] cum;
  logic [CW-1:0] ref_total;
  logic [CW-1:0] in_total;

  // Divider interface.
  logic          div_start;
  logic          div_done;
  logic [LW-1:0] div_q;
  logic [CW-1:0] cum_next;
  logic [CW-1:0] div_total;

  // Pixel addressing.
  logic [31:0]   px_wide;
  logic          px_in_range;
  logic [LW-1:0] px_addr;
  logic [LW-1:0] map_addr;
  logic [31:0]   final_wide;

  // Memory port controls.
  logic          clr_we;
  logic          ref_we;
  logic          in_we;
  logic [LW-1:0] hist_waddr;
  logic [LW-1:0] hist_raddr;
  logic [CW-1:0] ref_wdata;
  logic [CW-1:0] in_wdata;
  logic          inv_we;
  logic [LW-1:0] inv_wdata;
  logic          fin_we;
  logic [LW-1:0] fin_wdata;
  logic          take_left;

  assign px_wide     = {24'd0, pixel_value};
  assign px_in_range = (px_wide < 32'(LEVELS));
  assign px_addr     = px_wide[LW-1:0];
  // A map request beyond the top level uses the top level.
  assign map_addr    = px_in_range ? px_addr : LAST;

  assign busy = (state != ST_IDLE);

  assign cum_next  = cum + (pass ? in_q : ref_q);
  assign div_total = pass ? in_total : ref_total;
  assign div_start = (state == ST_RD);

  hmu_divider #(
    .LEVELS      (LEVELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .cum      (cum_next),
    .total    (div_total),
    .done     (div_done),
    .quotient (div_q)
  );

  // Histogram ports: the clearing pass writes zeros, an add writes back the
  // count read in the previous cycle plus one.
  assign clr_we     = (state == ST_CLEAR);
  assign ref_we     = clr_we || ((state == ST_ADD) && !add_sel);
  assign in_we      = clr_we || ((state == ST_ADD) && add_sel);
  assign hist_waddr = clr_we ? i : add_addr;
  assign ref_wdata  = clr_we ? '0 : ref_q + CW'(1);
  assign in_wdata   = clr_we ? '0 : in_q + CW'(1);
  assign hist_raddr = (state == ST_IDLE) ? px_addr : i;

  // Gap filling: a slot between two filled slots copies the nearer one, and
  // the left one on a tie. Slots below the first filled slot copy it, and slots above the last copy the last.
  assign take_left = haslp && ((w - lp) <= (p - w));
  assign inv_we    = (state == ST_FILL) || (state == ST_TAIL);
  always_comb begin
    if (state == ST_TAIL) begin
      inv_wdata = lv;
    end else if (w == p) begin
      inv_wdata = v;
    end else begin
      inv_wdata = take_left ? lv : v;
    end
  end

  assign fin_we    = clr_we || (state == ST_INV);
  assign fin_wdata = clr_we ? '0 : inv_q;

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_hist[hist_waddr] <= ref_wdata;
    end
    if (in_we) begin
      in_hist[hist_waddr] <= in_wdata;
    end
    ref_q <= ref_hist[hist_raddr];
    in_q  <= in_hist[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (inv_we) begin
      inv_map[w] <= inv_wdata;
    end
    inv_q <= inv_map[div_q];
  end

  always_ff @(posedge clk) begin
    if (fin_we) begin
      final_map[i] <= fin_wdata;
    end
    final_q <= final_map[map_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      i         <= '0;
      ref_total <= '0;
      in_total  <= '0;
      pass      <= 1'b0;
      first     <= 1'b1;
      haslp     <= 1'b0;
      ending    <= 1'b0;
      add_sel   <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (i == LAST) begin
            state <= ST_IDLE;
          end else begin
            i <= i + LW'(1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            case (op)
              OP_ADD_REF: begin
                if (px_in_range && (ref_total != '1)) begin
                  add_sel  <= 1'b0;
                  add_addr <= px_addr;
                  state    <= ST_ADD;
                end
              end
              OP_ADD_IN: begin
                if (px_in_range && (in_total != '1)) begin
                  add_sel  <= 1'b1;
                  add_addr <= px_addr;
                  state    <= ST_ADD;
                end
              end
              OP_BUILD: begin
                pass  <= 1'b0;
                i     <= '0;
                cum   <= '0;
                first <= 1'b1;
                haslp <= 1'b0;
                w     <= '0;
                state <= ST_ISSUE;
              end
              OP_MAP: begin
                state <= ST_MAP;
              end
              OP_CLEAR: begin
                i         <= '0;
                ref_total <= '0;
                in_total  <= '0;
                state     <= ST_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ADD: begin
          if (add_sel) begin
            in_total <= in_total + CW'(1);
          end else begin
            ref_total <= ref_total + CW'(1);
          end
          state <= ST_IDLE;
        end
        ST_MAP: begin
          state <= ST_IDLE;
        end
        ST_ISSUE: begin
          state <= ST_RD;
        end
        ST_RD: begin
          cum   <= cum_next;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            if (pass) begin
              state <= ST_INV;
            end else if (first || (div_q == p)) begin
              // Same slot as before, or the first slot: the later level wins.
              first <= 1'b0;
              p     <= div_q;
              v     <= i;
              if (i == LAST) begin
                ending <= 1'b1;
                state  <= ST_FILL;
              end else begin
                i     <= i + LW'(1);
                state <= ST_ISSUE;
              end
            end else begin
              np     <= div_q;
              nv     <= i;
              ending <= 1'b0;
              state  <= ST_FILL;
            end
          end
        end
        ST_FILL: begin
          w <= w + LW'(1);
          if (w == p) begin
            lp    <= p;
            lv    <= v;
            haslp <= 1'b1;
            if (ending) begin
              if (p == LAST) begin
                pass  <= 1'b1;
                i     <= '0;
                cum   <= '0;
                state <= ST_ISSUE;
              end else begin
                state <= ST_TAIL;
              end
            end else begin
              p <= np;
              v <= nv;
              if (i == LAST) begin
                ending <= 1'b1;
              end else begin
                i     <= i + LW'(1);
                state <= ST_ISSUE;
              end
            end
          end
        end
        ST_TAIL: begin
          if (w == LAST) begin
            pass  <= 1'b1;
            i     <= '0;
            cum   <= '0;
            state <= ST_ISSUE;
          end else begin
            w <= w + LW'(1);
          end
        end
        ST_INV: begin
          if (i == LAST) begin
            state <= ST_IDLE;
          end else begin
            i     <= i + LW'(1);
            state <= ST_ISSUE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign valid         = (state == ST_MAP);
  assign final_wide    = 32'(final_q);
  assign matched_value = final_wide[7:0];

`ifndef SYNTHESIS
  a_map_gives_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (op == OP_MAP) |=> valid) else $error("map request lost");
  a_result_single: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid) else $error("result repeated");
  a_result_only_after_map: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(start) && ($past(op) == OP_MAP)) else $error("result invented");
  a_div_only_in_build: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV)) else $error("divider result outside build");
`endif

endmodule

// File: verif/tb_histogram_matching_unit.sv
// ----------------------------------------------------------------------------
// tb_histogram_matching_unit: self-checking bench for the matching unit
// Drives a directed table and then random request streams. An in-bench model
// predicts each mapped pixel, and the bench checks every result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_histogram_matching_unit;
  import hmu_pkg::*;

  localparam int NLEV = LEVELS_DEFAULT;
  localparam int RANDOM_REQUESTS = 500;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [2:0] op;
  logic [7:0] pixel_value;
  logic       valid;
  logic [7:0] matched_value;

  histogram_matching_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .pixel_value(pixel_value), .valid(valid), .matched_value(matched_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow state of the unit, updated as each request is taken.
  int unsigned ref_hist [NLEV];
  int unsigned in_hist [NLEV];
  int unsigned ref_total;
  int unsigned in_total;
  logic [7:0]  match_lut [NLEV];

  logic [7:0] pending_matches [$];
  int errors;
  int map_count;
  int build_count;
  int request_count;

  typedef struct {
    logic [2:0] code;
    logic [7:0] level;
    bit         known;
    logic [7:0] answer;
  } row_t;

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    errors++;
    $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  function automatic int unsigned scale_level(longint unsigned cum, longint unsigned total);
    longint unsigned s;
    if (total == 0) return 0;
    s = ((NLEV - 1) * cum) / total;
    return (s >= NLEV) ? NLEV - 1 : int'(s);
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < NLEV; i++) begin
      ref_hist[i] = 0;
      in_hist[i] = 0;
      match_lut[i] = '0;
    end
    ref_total = 0;
    in_total = 0;
  endfunction

  // Builds the matching map: invert the reference transfer, fill gaps from
  // the nearest filled slot (left side first), then compose with the input
  // transfer.
  function automatic void build_match_lut();
    logic [7:0] inv [NLEV];
    bit         filled [NLEV];
    longint unsigned cum;
    int unsigned s;
    for (int i = 0; i < NLEV; i++) begin
      inv[i] = '0;
      filled[i] = 1'b0;
    end
    cum = 0;
    for (int i = 0; i < NLEV; i++) begin
      cum += ref_hist[i];
      s = scale_level(cum, ref_total);
      inv[s] = i[7:0];
      filled[s] = 1'b1;
    end
    for (int i = 0; i < NLEV; i++) begin
      if (!filled[i]) begin
        for (int d = 1; i - d >= 0 || i + d < NLEV; d++) begin
          if (i - d >= 0 && filled[i - d]) begin
            inv[i] = inv[i - d];
            break;
          end
          if (i + d < NLEV && filled[i + d]) begin
            inv[i] = inv[i + d];
            break;
          end
        end
      end
    end
    cum = 0;
    for (int i = 0; i < NLEV; i++) begin
      cum += in_hist[i];
      match_lut[i] = inv[scale_level(cum, in_total)];
    end
  endfunction

  // Applies one taken request to the shadow state and returns the expected
  // matched level for a map request.
  function automatic logic [7:0] apply_request(input logic [2:0] code, input logic [7:0] level);
    logic [7:0] r;
    r = '0;
    case (code)
      OP_ADD_REF: begin
        if (ref_total < (1 << COUNT_WIDTH_DEFAULT) - 1) begin
          ref_hist[level]++;
          ref_total++;
        end
      end
      OP_ADD_IN: begin
        if (in_total < (1 << COUNT_WIDTH_DEFAULT) - 1) begin
          in_hist[level]++;
          in_total++;
        end
      end
      OP_BUILD: build_match_lut();
      OP_MAP:   r = match_lut[level];
      OP_CLEAR: clear_shadow();
      default: ;
    endcase
    return r;
  endfunction

  // Holds a request on the ports until the unit takes it, then idles for a
  // random number of cycles. Start stays high across back-to-back requests.
  task automatic send_request(input logic [2:0] code, input logic [7:0] level,
                              input bit known, input logic [7:0] answer);
    logic [7:0] want;
    int gap;
    start <= 1'b1;
    op <= code;
    pixel_value <= level;
    do @(posedge clk); while (busy);
    want = apply_request(code, level);
    request_count++;
    if (code == OP_MAP) begin
      if (known && want !== answer) report("table vs model", want, answer);
      pending_matches.push_back(known ? answer : want);
      map_count++;
    end
    if (code == OP_BUILD) build_count++;
    gap = $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_matches();
    start <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result checker: the unit strobes valid for one cycle per map request.
  always @(posedge clk) begin
    if (!rst && valid) begin
      if (pending_matches.size() == 0) begin
        errors++;
        $display("%0t unexpected result %0d", $realtime, matched_value);
      end else begin
        logic [7:0] want;
        want = pending_matches.pop_front();
        if (matched_value !== want) report("matched_value", matched_value, want);
      end
    end
  end

  // Directed table. Rows with a typed answer are read straight off the
  // behavior: maps before any build or after a clear are zero, and a build
  // over an empty reference histogram sends every level to the top level,
  // since all reference levels land on slot zero and the last one wins.
  row_t table_rows [] = '{
    '{OP_MAP,     8'd0,   1'b1, 8'd0},
    '{OP_MAP,     8'd255, 1'b1, 8'd0},
    '{3'd5,       8'd17,  1'b0, 8'd0},
    '{3'd6,       8'd200, 1'b0, 8'd0},
    '{3'd7,       8'd255, 1'b0, 8'd0},
    '{OP_BUILD,   8'd0,   1'b0, 8'd0},
    '{OP_MAP,     8'd77,  1'b1, 8'd255},
    '{OP_ADD_REF, 8'd0,   1'b0, 8'd0},
    '{OP_ADD_REF, 8'd255, 1'b0, 8'd0},
    '{OP_ADD_REF, 8'd255, 1'b0, 8'd0},
    '{OP_ADD_IN,  8'd0,   1'b0, 8'd0},
    '{OP_ADD_IN,  8'd128, 1'b0, 8'd0},
    '{OP_ADD_IN,  8'd255, 1'b0, 8'd0},
    '{OP_MAP,     8'd128, 1'b1, 8'd255},
    '{OP_BUILD,   8'd0,   1'b0, 8'd0},
    '{OP_MAP,     8'd0,   1'b0, 8'd0},
    '{OP_MAP,     8'd128, 1'b0, 8'd0},
    '{OP_MAP,     8'd255, 1'b0, 8'd0},
    '{OP_CLEAR,   8'd0,   1'b0, 8'd0},
    '{OP_MAP,     8'd255, 1'b1, 8'd0},
    '{OP_ADD_IN,  8'd9,   1'b0, 8'd0},
    '{OP_BUILD,   8'd0,   1'b0, 8'd0},
    '{OP_MAP,     8'd9,   1'b1, 8'd255},
    '{OP_MAP,     8'd3,   1'b1, 8'd255}
  };

  // Draws a random request. Most are adds that shape the histograms, with
  // maps to probe the result and an occasional build, clear or unused code.
  task automatic random_request(input int lo, input int hi);
    int pick;
    logic [2:0] code;
    logic [7:0] level;
    pick = $urandom_range(0, 199);
    if (pick < 110)      code = $urandom_range(0, 1) ? OP_ADD_IN : OP_ADD_REF;
    else if (pick < 188) code = OP_MAP;
    else if (pick < 193) code = OP_BUILD;
    else if (pick < 195) code = OP_CLEAR;
    else                 code = 3'($urandom_range(5, 7));
    level = (code == OP_MAP) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(lo, hi));
    send_request(code, level, 1'b0, 8'd0);
  endtask

  initial begin
    int lo;
    int hi;
    rst = 1'b1;
    start <= 1'b0;
    op <= OP_ADD_REF;
    pixel_value <= '0;
    errors = 0;
    map_count = 0;
    build_count = 0;
    request_count = 0;
    clear_shadow();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (table_rows[k])
      send_request(table_rows[k].code, table_rows[k].level, table_rows[k].known,
                   table_rows[k].answer);
    // Let every outstanding result land before the random part starts.
    drain_matches();

    // Random part in bursts: each burst draws the added pixels from a random window so
    // that histograms get clustered and the inverse map has gaps to fill.
    lo = 0;
    hi = 255;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0) begin
        lo = $urandom_range(0, 255);
        hi = $urandom_range(0, 2) == 0 ? 255 : $urandom_range(lo, 255);
        if ($urandom_range(0, 3) == 0) lo = 0;
        send_request(OP_BUILD, 8'($urandom_range(0, 255)), 1'b0, 8'd0);
      end
      if (n == RANDOM_REQUESTS / 2) drain_matches();
      random_request(lo, hi);
    end
    send_request(OP_BUILD, 8'd0, 1'b0, 8'd0);
    for (int v = 0; v < 8; v++) send_request(OP_MAP, 8'($urandom_range(0, 255)), 1'b0, 8'd0);

    drain_matches();
    repeat (20) @(posedge clk);
    $display("tb: %0d requests taken, %0d builds, %0d mapped pixels checked",
             request_count, build_count, map_count);
    $display("tb: %0d mismatches", errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: histogram_matching_unit.f
sv/hmu_pkg.sv
sv/hmu_divider.sv
sv/histogram_matching_unit.sv
verif/tb_histogram_matching_unit.sv
